// ===== hw/rtl/psp_pkg.sv =====
// Shared types, codes and the CRC-32 byte step for the PAT section parser.
package psp_pkg;

   // Result kinds
   localparam logic [1:0] KIND_ENTRY  = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // Reject reasons
   localparam logic [1:0] REASON_TID      = 2'd0;
   localparam logic [1:0] REASON_SYNTAX   = 2'd1;
   localparam logic [1:0] REASON_LENGTH   = 2'd2;
   localparam logic [1:0] REASON_CRC      = 2'd3;

   // Configuration register indexes
   localparam logic CSR_WANT_TID = 1'b0;
   localparam logic CSR_MAX_LEN  = 1'b1;

   localparam logic [7:0]  RESET_TID         = 8'd0;
   localparam logic [11:0] RESET_MAX_LENGTH  = 12'd1021;
   localparam logic [11:0] MIN_LENGTH        = 12'd9;
   localparam logic [11:0] CRC_BYTES         = 12'd4;
   localparam logic [31:0] CRC_POLY          = 32'h04C1_1DB7;
   localparam logic [7:0]  VERSION_MASK      = 8'h3E;
   localparam int          QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] prog_num;
      logic [12:0] pmt_pid;
      logic [15:0] stream_id;
      logic [4:0]  version_number;
      logic [7:0]  section_number;
      logic [7:0]  last_section_number;
      logic [1:0]  reject_reason;
      logic        last_result;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]  want_tid;
      logic [11:0] max_len;
   } cfg_type;

   // Results produced by one request: count is 0, 1 or 2
   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type res0;
      rsp_payload_type res1;
   } push_type;

   // MPEG-2 CRC-32, MSB first, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'h0};
      for (int i = 0; i < 8; i++) begin
         c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/pat_section_parser.sv =====
// Top level of the PAT section parser: configuration registers, parser and result queue.
//
// Takes one PAT section byte per cycle, with first_byte flagging the table id byte.
// Program entries come out as their loop groups complete, ahead of the CRC check; the
// status result (accept with header fields, or reject with a reason) ends each section,
// and a consumer drops the entries of a rejected section. Each byte goes through the input
// register and the parser into the result queue, which drives rsp_valid. Sustained rate
// is one byte per cycle while the queue has room; the input register stalls only while
// the result queue (QUEUE_DEPTH entries, a power of two of at least 2) lacks room for two
// results; with QUEUE_DEPTH above 2 that happens only when the consumer holds
// rsp_ready low.
module pat_section_parser #(
   parameter int QUEUE_DEPTH = psp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  psp_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output psp_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [11:0]               csr_data
);

   psp_pkg::cfg_type  cfg_ff;
   psp_pkg::push_type push;
   logic              push_valid;
   logic              queue_room;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.want_tid <= psp_pkg::RESET_TID;
         cfg_ff.max_len  <= psp_pkg::RESET_MAX_LENGTH;
      end else if (csr_write_enable) begin
         case (csr_index)
            psp_pkg::CSR_WANT_TID: cfg_ff.want_tid <= csr_data[7:0];
            psp_pkg::CSR_MAX_LEN:  cfg_ff.max_len  <= csr_data;
            default: ;
         endcase
      end
   end

   psp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_room  (queue_room),
      .push_valid  (push_valid),
      .push        (push)
   );

   psp_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push        (push),
      .room        (queue_room),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hw/rtl/psp_parser.sv =====
// Input register and single-pass section parsing datapath.
module psp_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  psp_pkg::cfg_type          cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  psp_pkg::req_payload_type  req_payload,
   input  logic                      queue_room,
   output logic                      push_valid,
   output psp_pkg::push_type         push
);

   logic                     in_valid_ff, in_valid_in;
   psp_pkg::req_payload_type in_data_ff;
   logic                     advance;

   logic [11:0] pos_ff, pos_in;
   logic [11:0] len_ff, len_in;
   logic [31:0] crc_ff, crc_in;
   logic        mis_ff, mis_in;
   logic [23:0] ent_ff, ent_in;
   logic [15:0] sid_ff, sid_in;
   logic [20:0] num_ff, num_in;
   logic        skip_ff, skip_in;

   logic                    restart_hit;
   logic                    main_hit;
   psp_pkg::rsp_payload_type main_res;
   psp_pkg::rsp_payload_type restart_res;
   logic [7:0]              b;
   logic [11:0]             len_v;
   logic [11:0]             body_end;
   logic [11:0]             j_v;
   logic [11:0]             grp_v;
   logic [7:0]              want;

   // Take a new request when the register is empty or drains this cycle
   assign advance     = in_valid_ff && queue_room;
   assign req_ready   = !in_valid_ff || queue_room;
   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign b           = in_data_ff.data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
   end

   // Restart reject for a section cut short by a new first byte
   always_comb begin
      restart_res               = '0;
      restart_res.kind          = psp_pkg::KIND_REJECT;
      restart_res.reject_reason = psp_pkg::REASON_LENGTH;
      restart_res.last_result   = 1'b1;
   end

   // Parse one byte against the current section state
   always_comb begin
      pos_in      = pos_ff;
      len_in      = len_ff;
      crc_in      = crc_ff;
      mis_in      = mis_ff;
      ent_in      = ent_ff;
      sid_in      = sid_ff;
      num_in      = num_ff;
      skip_in     = skip_ff;
      restart_hit = 1'b0;
      main_hit    = 1'b0;
      main_res    = '0;
      len_v       = {ent_ff[3:0], b};
      body_end    = len_ff - psp_pkg::CRC_BYTES;
      j_v         = '0;
      grp_v       = '0;
      want        = '0;

      if (in_data_ff.first_byte) begin
         restart_hit = !skip_ff;
         skip_in     = 1'b0;
         pos_in      = '0;
         len_in      = '0;
         crc_in      = '1;
         mis_in      = 1'b0;
         ent_in      = '0;
         sid_in      = '0;
         num_in      = '0;
      end

      if (!skip_in) begin
         if (len_in == '0) begin
            // Prefix: table id, flags with length high nibble, length low byte
            case (pos_in)
               12'd0: begin
                  if (b != cfg.want_tid) begin
                     main_hit               = 1'b1;
                     main_res.kind          = psp_pkg::KIND_REJECT;
                     main_res.reject_reason = psp_pkg::REASON_TID;
                     main_res.last_result   = 1'b1;
                     skip_in                = 1'b1;
                  end else begin
                     crc_in = psp_pkg::crc_byte(crc_in, b);
                     pos_in = 12'd1;
                  end
               end
               12'd1: begin
                  if (!b[7]) begin
                     main_hit               = 1'b1;
                     main_res.kind          = psp_pkg::KIND_REJECT;
                     main_res.reject_reason = psp_pkg::REASON_SYNTAX;
                     main_res.last_result   = 1'b1;
                     skip_in                = 1'b1;
                  end else begin
                     crc_in = psp_pkg::crc_byte(crc_in, b);
                     ent_in = {20'h0, b[3:0]};
                     pos_in = 12'd2;
                  end
               end
               default: begin
                  len_v  = {ent_in[3:0], b};
                  crc_in = psp_pkg::crc_byte(crc_in, b);
                  if (len_v < psp_pkg::MIN_LENGTH || len_v > cfg.max_len) begin
                     main_hit               = 1'b1;
                     main_res.kind          = psp_pkg::KIND_REJECT;
                     main_res.reject_reason = psp_pkg::REASON_LENGTH;
                     main_res.last_result   = 1'b1;
                     skip_in                = 1'b1;
                  end else begin
                     len_in = len_v;
                     pos_in = '0;
                     ent_in = '0;
                  end
               end
            endcase
         end else if (pos_in < body_end) begin
            // Body: header fields, then 4-byte program loop groups
            crc_in = psp_pkg::crc_byte(crc_in, b);
            grp_v  = pos_in - 12'd5;
            if (pos_in < 12'd2) begin
               sid_in = {sid_in[7:0], b};
            end else if (pos_in == 12'd2) begin
               num_in = {5'((b & psp_pkg::VERSION_MASK) >> 1), 16'h0};
            end else if (pos_in == 12'd3) begin
               num_in[15:8] = b;
            end else if (pos_in == 12'd4) begin
               num_in[7:0] = b;
            end else if (grp_v[1:0] == 2'd3) begin
               main_hit                = 1'b1;
               main_res.kind           = psp_pkg::KIND_ENTRY;
               main_res.prog_num       = ent_in[23:8];
               main_res.pmt_pid        = {ent_in[4:0], b};
               ent_in                  = '0;
            end else begin
               ent_in = {ent_in[15:0], b};
            end
            pos_in = pos_in + 12'd1;
         end else begin
            // Trailer: compare against the running CRC, MSB byte first
            j_v = pos_in - body_end;
            case (j_v[1:0])
               2'd0:    want = crc_in[31:24];
               2'd1:    want = crc_in[23:16];
               2'd2:    want = crc_in[15:8];
               default: want = crc_in[7:0];
            endcase
            if (want != b) begin
               mis_in = 1'b1;
            end
            if (({1'b0, pos_in} + 13'd1) >= {1'b0, len_in}) begin
               main_hit             = 1'b1;
               main_res.last_result = 1'b1;
               skip_in              = 1'b1;
               if (mis_in) begin
                  main_res.kind          = psp_pkg::KIND_REJECT;
                  main_res.reject_reason = psp_pkg::REASON_CRC;
               end else begin
                  main_res.kind                = psp_pkg::KIND_ACCEPT;
                  main_res.stream_id           = sid_in;
                  main_res.version_number      = num_in[20:16];
                  main_res.section_number      = num_in[15:8];
                  main_res.last_section_number = num_in[7:0];
               end
            end else begin
               pos_in = pos_in + 12'd1;
            end
         end
      end
   end

   // Pack up to two results for the output queue
   always_comb begin
      push = '0;
      if (restart_hit) begin
         push.res0  = restart_res;
         push.res1  = main_res;
         push.count = main_hit ? 2'd2 : 2'd1;
      end else begin
         push.res0  = main_res;
         push.res1  = '0;
         push.count = main_hit ? 2'd1 : 2'd0;
      end
   end

   assign push_valid = advance;

   // Hold section state, advance on each parsed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         len_ff  <= '0;
         crc_ff  <= '1;
         mis_ff  <= 1'b0;
         ent_ff  <= '0;
         sid_ff  <= '0;
         num_ff  <= '0;
         skip_ff <= 1'b1;
      end else if (advance) begin
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         crc_ff  <= crc_in;
         mis_ff  <= mis_in;
         ent_ff  <= ent_in;
         sid_ff  <= sid_in;
         num_ff  <= num_in;
         skip_ff <= skip_in;
      end
   end

   a_two_only_on_first: assert property (@(posedge clock) disable iff (reset)
      (advance && push.count == 2'd2) |-> in_data_ff.first_byte)
      else $error("two results from a byte without the first flag");

   a_length_in_range: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) |-> (len_ff >= psp_pkg::MIN_LENGTH))
      else $error("open section with a length below the minimum");

   a_entry_not_last: assert property (@(posedge clock) disable iff (reset)
      (advance && push.count != 2'd0 && push.res0.kind == psp_pkg::KIND_ENTRY)
      |-> !push.res0.last_result)
      else $error("program entry marked as last result");

   a_status_then_skip: assert property (@(posedge clock) disable iff (reset)
      (advance && main_hit && main_res.last_result) |=> skip_ff)
      else $error("parser did not skip after a status result");

endmodule

// ===== hw/rtl/psp_out_queue.sv =====
// Result queue that takes up to two results a cycle and returns one.
module psp_out_queue #(
   parameter int DEPTH = psp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  psp_pkg::push_type         push,
   output logic                      room,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output psp_pkg::rsp_payload_type  rsp_payload
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   psp_pkg::rsp_payload_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] push_n;
   logic          pop;

   assign push_n      = push_valid ? CW'(push.count) : '0;
   assign pop         = rsp_valid && rsp_ready;
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = mem_ff[rd_ptr_ff];
   assign room        = (count_ff <= CW'(DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + AW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + AW'(pop);
   assign count_in  = count_ff + push_n - CW'(pop);

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the results in order
   always_ff @(posedge clock) begin
      if (push_n != '0) begin
         mem_ff[wr_ptr_ff] <= push.res0;
      end
      if (push_n == CW'(2)) begin
         mem_ff[wr_ptr_ff + AW'(1)] <= push.res1;
      end
   end

endmodule

// ===== sim/pat_section_parser_tb.sv =====
// Self-checking testbench for the PAT section parser: random sections, idling and CSR phases.
module pat_section_parser_tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   psp_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   psp_pkg::rsp_payload_type rsp_payload;
   logic                     csr_write_enable = 1'b0;
   logic                     csr_index = psp_pkg::CSR_WANT_TID;
   logic [11:0]              csr_data = '0;

   pat_section_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Request bytes waiting to be driven and results still owed by the parser
   psp_pkg::req_payload_type pending_requests[$];
   psp_pkg::rsp_payload_type expected_results[$];
   int              queued_count = 0;
   int              accepted_count = 0;
   int              fail_count = 0;
   int              cycle_count = 0;

   // Handshake bookkeeping for the drivers
   logic            req_taken = 1'b0;
   logic            rsp_taken = 1'b0;
   int unsigned     req_gap = 0;
   int unsigned     rsp_stall = 0;
   bit              req_burst = 1'b0;
   bit              rsp_burst = 1'b0;

   // Parser shadow: configuration and section state
   logic [7:0]      cfg_tid = psp_pkg::RESET_TID;
   logic [11:0]     cfg_max_len = psp_pkg::RESET_MAX_LENGTH;
   logic [11:0]     pos = '0;
   logic [11:0]     len_field = '0;
   logic [31:0]     crc = '1;
   logic            crc_bad = 1'b0;
   logic [23:0]     entry_acc = '0;
   logic [15:0]     hdr_ts_id = '0;
   logic [20:0]     hdr_num = '0;
   logic            skip = 1'b1;

   // Clock; the single reset pulse is driven by the stimulus sequence
   initial begin
      forever #2 clock = ~clock;
   end

   // MPEG-2 CRC-32, one message bit at a time, MSB first
   function automatic logic [31:0] crc32_advance(input logic [31:0] state, input logic [7:0] octet);
      logic [31:0] s;
      logic        fb;
      s = state;
      for (int k = 7; k >= 0; k--) begin
         fb = s[31] ^ octet[k];
         s = {s[30:0], 1'b0};
         if (fb) s = s ^ psp_pkg::CRC_POLY;
      end
      return s;
   endfunction

   task automatic push_reject(input logic [1:0] reason);
      psp_pkg::rsp_payload_type r;
      r = '0;
      r.kind = psp_pkg::KIND_REJECT;
      r.reject_reason = reason;
      r.last_result = 1'b1;
      expected_results.push_back(r);
      skip = 1'b1;
   endtask

   // Advance the shadow parser by one accepted byte and queue the results it causes
   task automatic parse_byte(input logic [7:0] b, input logic first);
      logic [11:0]              i;
      logic [11:0]              body_end;
      logic [11:0]              len;
      logic [11:0]              loop_idx;
      logic [1:0]               j;
      psp_pkg::rsp_payload_type r;
      if (first) begin
         if (!skip) push_reject(psp_pkg::REASON_LENGTH);
         skip = 1'b0;
         pos = '0;
         len_field = '0;
         crc = '1;
         crc_bad = 1'b0;
         entry_acc = '0;
         hdr_ts_id = '0;
         hdr_num = '0;
      end
      if (skip) return;

      // Prefix: table id, syntax/length high nibble, length low byte
      if (len_field == 0) begin
         if (pos == 0) begin
            if (b != cfg_tid) begin
               push_reject(psp_pkg::REASON_TID);
               return;
            end
            crc = crc32_advance(crc, b);
            pos = 12'd1;
         end else if (pos == 1) begin
            if (!b[7]) begin
               push_reject(psp_pkg::REASON_SYNTAX);
               return;
            end
            crc = crc32_advance(crc, b);
            entry_acc = {20'h0, b[3:0]};
            pos = 12'd2;
         end else begin
            len = {entry_acc[3:0], b};
            crc = crc32_advance(crc, b);
            if (len < psp_pkg::MIN_LENGTH || len > cfg_max_len) begin
               push_reject(psp_pkg::REASON_LENGTH);
               return;
            end
            len_field = len;
            pos = '0;
            entry_acc = '0;
         end
         return;
      end

      i = pos;
      body_end = len_field - psp_pkg::CRC_BYTES;
      if (i < body_end) begin
         // Body: header fields, then 4-byte program loop groups
         crc = crc32_advance(crc, b);
         loop_idx = i - 12'd5;
         if (i < 2) begin
            hdr_ts_id = {hdr_ts_id[7:0], b};
         end else if (i == 2) begin
            hdr_num = {5'((b & psp_pkg::VERSION_MASK) >> 1), 16'h0};
         end else if (i == 3) begin
            hdr_num[15:8] = b;
         end else if (i == 4) begin
            hdr_num[7:0] = b;
         end else if (loop_idx[1:0] == 2'd3) begin
            r = '0;
            r.kind = psp_pkg::KIND_ENTRY;
            r.prog_num = entry_acc[23:8];
            r.pmt_pid = {entry_acc[4:0], b};
            expected_results.push_back(r);
            entry_acc = '0;
         end else begin
            entry_acc = {entry_acc[15:0], b};
         end
      end else begin
         // Trailer: compare against the running CRC, decide on the last byte
         j = 2'(i - body_end);
         if (crc[(3 - j) * 8 +: 8] != b) crc_bad = 1'b1;
         if (int'(i) + 1 >= int'(len_field)) begin
            if (crc_bad) begin
               push_reject(psp_pkg::REASON_CRC);
               return;
            end
            r = '0;
            r.kind = psp_pkg::KIND_ACCEPT;
            r.stream_id = hdr_ts_id;
            r.version_number = hdr_num[20:16];
            r.section_number = hdr_num[15:8];
            r.last_section_number = hdr_num[7:0];
            r.last_result = 1'b1;
            expected_results.push_back(r);
            skip = 1'b1;
            return;
         end
      end
      pos = i + 12'd1;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_result(input psp_pkg::rsp_payload_type want,
                               input psp_pkg::rsp_payload_type got);
      check_field("kind", 32'(want.kind), 32'(got.kind));
      check_field("prog_num", 32'(want.prog_num), 32'(got.prog_num));
      check_field("pmt_pid", 32'(want.pmt_pid), 32'(got.pmt_pid));
      check_field("stream_id", 32'(want.stream_id), 32'(got.stream_id));
      check_field("version_number", 32'(want.version_number), 32'(got.version_number));
      check_field("section_number", 32'(want.section_number), 32'(got.section_number));
      check_field("last_section_number", 32'(want.last_section_number),
                  32'(got.last_section_number));
      check_field("reject_reason", 32'(want.reject_reason), 32'(got.reject_reason));
      check_field("last_result", 32'(want.last_result), 32'(got.last_result));
   endtask

   // Monitor: check results, then predict from the accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: kind %0h", rsp_payload.kind);
               fail_count++;
            end else begin
               check_result(expected_results.pop_front(), rsp_payload);
            end
         end
         if (req_valid && req_ready) begin
            parse_byte(req_payload.data_byte, req_payload.first_byte);
            accepted_count++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("pat_section_parser_tb: FAIL");
         $finish;
      end
   end

   // Request driver: hold until accepted, then idle for the drawn gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_requests.size() != 0) begin
            req_payload <= pending_requests.pop_front();
            req_valid <= 1'b1;
            req_gap <= req_burst ? 0 : $urandom_range(0, 9);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result ready: stall for a drawn number of cycles after each result
   always @(negedge clock) begin : drive_ready
      int unsigned stall;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_taken) begin
         stall = rsp_burst ? 0 : $urandom_range(0, 9);
         rsp_ready <= (stall == 0);
         rsp_stall <= (stall == 0) ? 0 : stall - 1;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic push_request(input logic [7:0] b, input logic f);
      psp_pkg::req_payload_type item;
      item.data_byte = b;
      item.first_byte = f;
      pending_requests.push_back(item);
      queued_count++;
   endtask

   // Wait until every request is taken and every result has come, then settle
   task automatic wait_idle();
      do @(negedge clock);
      while (accepted_count != queued_count || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [11:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == psp_pkg::CSR_WANT_TID) cfg_tid = value[7:0];
      else cfg_max_len = value;
   endtask

   // Build one section with a correct or corrupted CRC; cut > 0 truncates it
   task automatic queue_section(input logic [7:0] tid, input logic syntax, input logic [11:0] len,
                                input logic bad_crc, input int cut);
      logic [7:0]  octets[$];
      logic [31:0] c;
      logic        len_ok;
      int          body_len;
      int          n;
      len_ok = (len >= psp_pkg::MIN_LENGTH && len <= cfg_max_len);
      octets.push_back(tid);
      octets.push_back({syntax, 3'($urandom), len[11:8]});
      octets.push_back(len[7:0]);
      body_len = len_ok ? int'(len) - 4 : $urandom_range(0, 4);
      for (n = 0; n < body_len; n++) octets.push_back(8'($urandom));
      c = '1;
      foreach (octets[k]) c = crc32_advance(c, octets[k]);
      if (bad_crc) c = c ^ (32'h1 << $urandom_range(0, 31));
      if (len_ok) begin
         octets.push_back(c[31:24]);
         octets.push_back(c[23:16]);
         octets.push_back(c[15:8]);
         octets.push_back(c[7:0]);
      end
      n = (cut > 0 && cut < octets.size()) ? cut : octets.size();
      for (int k = 0; k < n; k++) push_request(octets[k], k == 0);
   endtask

   task automatic queue_random_section();
      int          pick;
      int          top;
      logic [11:0] len;
      pick = $urandom_range(0, 99);
      top = (cfg_max_len < 12'd48) ? int'(cfg_max_len) : 48;
      len = 12'($urandom_range(9, top));
      if (pick < 60) begin
         queue_section(cfg_tid, 1'b1, len, 1'b0, 0);
      end else if (pick < 70) begin
         queue_section(cfg_tid, 1'b1, len, 1'b1, 0);
      end else if (pick < 78) begin
         queue_section(cfg_tid, 1'b1, len, 1'($urandom), $urandom_range(1, int'(len) + 2));
      end else if (pick < 83) begin
         queue_section(cfg_tid ^ 8'($urandom_range(1, 255)), 1'b1, len, 1'b0, 0);
      end else if (pick < 88) begin
         queue_section(cfg_tid, 1'b0, len, 1'b0, 0);
      end else if (pick < 95) begin
         // Length out of range, either side
         if (cfg_max_len < 12'd4095 && $urandom_range(0, 1) == 1)
            len = 12'($urandom_range(int'(cfg_max_len) + 1, 4095));
         else
            len = 12'($urandom_range(0, 8));
         queue_section(cfg_tid, 1'b1, len, 1'b0, 0);
      end else begin
         // Noise with a sprinkling of start flags
         repeat ($urandom_range(1, 8)) push_request(8'($urandom), $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic queue_random_chunk(input int target);
      int start;
      start = queued_count;
      req_burst = ($urandom_range(0, 3) == 0);
      rsp_burst = ($urandom_range(0, 3) == 0);
      while (queued_count - start < target) begin
         queue_random_section();
         if ($urandom_range(0, 4) == 0) push_request(8'($urandom), 1'b0);
      end
   endtask

   // One configuration setting, two random chunks with a full drain between
   task automatic run_phase(input logic [7:0] tid, input logic [11:0] max_len, input int items);
      write_csr(psp_pkg::CSR_WANT_TID, {4'($urandom), tid});
      write_csr(psp_pkg::CSR_MAX_LEN, max_len);
      @(posedge clock);
      queue_random_chunk(items / 2);
      wait_idle();
      @(posedge clock);
      queue_random_chunk(items - items / 2);
      wait_idle();
   endtask

   // Stimulus sequence
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_csr(psp_pkg::CSR_WANT_TID, {4'($urandom), psp_pkg::RESET_TID});
      write_csr(psp_pkg::CSR_MAX_LEN, psp_pkg::RESET_MAX_LENGTH);
      @(posedge clock);
      // Idle byte before any start flag
      push_request(8'h5A, 1'b0);
      // Wrong table id
      push_request(8'h01, 1'b1);
      // Syntax indicator clear
      push_request(8'h00, 1'b1);
      push_request(8'h7F, 1'b0);
      // Shortest useful section with one ragged loop byte, then an ignored byte
      queue_section(8'h00, 1'b1, 12'd10, 1'b0, 0);
      push_request(8'hFF, 1'b0);
      // Section cut short by a restart whose length is below the minimum
      queue_section(8'h00, 1'b1, 12'd40, 1'b0, 4);
      queue_section(8'h00, 1'b1, 12'd8, 1'b0, 3);
      wait_idle();

      run_phase(8'h00, psp_pkg::RESET_MAX_LENGTH, 100);
      run_phase(8'hFF, 12'd4095, 100);
      // One long section, sent back to back
      @(posedge clock);
      req_burst = 1'b1;
      queue_section(8'hFF, 1'b1, 12'd64, 1'b0, 0);
      wait_idle();
      run_phase(8'($urandom), psp_pkg::MIN_LENGTH, 80);
      run_phase(8'($urandom), 12'($urandom_range(9, 100)), 100);
      run_phase(8'($urandom), 12'($urandom_range(9, 4095)), 100);

      if (fail_count == 0) begin
         $display("pat_section_parser_tb: PASS");
      end else begin
         $display("pat_section_parser_tb: FAIL");
      end
      $finish;
   end

endmodule
